// File: sv/message_header_deframer_defines.svh
// ----------------------------------------------------------------------------
// message_header_deframer_defines
// Assertion macros shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_HEADER_DEFRAMER_DEFINES_SVH
`define MESSAGE_HEADER_DEFRAMER_DEFINES_SVH

// check a property at every clock edge outside reset
`define MHD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check a property at every clock edge, reset included
`define MHD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg
// Types and constants of the message header deframer.
// ----------------------------------------------------------------------------
package mhd_pkg;

	localparam int HDR_LEN = 24;
	localparam int POS_W   = 5;

	localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(HDR_LEN);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HDR_LEN - 1);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(2);
	localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(8);
	localparam logic [POS_W-1:0] POS_TIME    = POS_W'(16);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int OUT_DATA_W = 184;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_VERSION = 2'd1,
		CFG_LIMIT   = 2'd2
	} mhd_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_TOO_LONG    = 3'd4
	} mhd_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} mhd_item_t;

	typedef struct packed {
		logic [15:0] expected_magic;
		logic [7:0]  supported_version;
		logic [31:0] body_length_limit;
	} mhd_cfg_t;

	typedef struct packed {
		mhd_status_t        status;
		logic [7:0]         header_version;
		logic [7:0]         message_type;
		logic [31:0]        body_length;
		logic [63:0]        sequence_number;
		logic signed [63:0] timestamp;
	} mhd_result_t;

endpackage

// File: sv/mhd_parse.sv
// ----------------------------------------------------------------------------
// mhd_parse
// Header field gathering, position tracking and header checks.
// ----------------------------------------------------------------------------
`include "message_header_deframer_defines.svh"

module mhd_parse
	import mhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  mhd_item_t   item,
	input  mhd_cfg_t    cfg,
	output logic        hit,
	output mhd_result_t res
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic [POS_W-1:0] pos_d;
	logic [15:0]      magic_q;
	logic [7:0]       version_q;
	logic [7:0]       type_q;
	logic [31:0]      length_q;
	logic [63:0]      seq_q;
	logic [63:0]      time_q;
	logic             active;
	logic             complete;
	mhd_status_t      status;

	assign pos_eff  = item.first_byte ? '0 : pos_q;
	assign active   = (pos_eff < POS_IDLE);
	assign complete = active && (pos_eff == POS_LAST);
	assign hit      = active && (complete || item.last_byte);

	always_comb begin
		priority if (!complete) begin
			status = ST_TOO_SHORT;
		end else if (magic_q != cfg.expected_magic) begin
			status = ST_BAD_MAGIC;
		end else if (version_q != cfg.supported_version) begin
			status = ST_BAD_VERSION;
		end else if (length_q > cfg.body_length_limit) begin
			status = ST_TOO_LONG;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.header_version  = version_q;
			res.message_type    = type_q;
			res.body_length     = length_q;
			res.sequence_number = seq_q;
			res.timestamp       = {time_q[55:0], item.data_byte};
		end
	end

	always_comb begin
		if (!active || hit) begin
			pos_d = POS_IDLE;
		end else begin
			pos_d = pos_eff + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && active) begin
			priority if (pos_eff < POS_VERSION) begin
				magic_q <= {magic_q[7:0], item.data_byte};
			end else if (pos_eff == POS_VERSION) begin
				version_q <= item.data_byte;
			end else if (pos_eff == POS_TYPE) begin
				type_q <= item.data_byte;
			end else if (pos_eff < POS_SEQ) begin
				length_q <= {length_q[23:0], item.data_byte};
			end else if (pos_eff < POS_TIME) begin
				seq_q <= {seq_q[55:0], item.data_byte};
			end else begin
				time_q <= {time_q[55:0], item.data_byte};
			end
		end
	end

	`MHD_ASSERT(a_pos_range, pos_q <= POS_IDLE, "byte position beyond idle")
	`MHD_ASSERT(a_idle_after_result, step && hit |=> pos_q == POS_IDLE,
		"position not idle after a result")
	`MHD_ASSERT(a_fail_zero, hit && res.status != ST_OK |-> res.header_version == '0 &&
		res.message_type == '0 && res.body_length == '0 && res.sequence_number == '0 &&
		res.timestamp == '0, "failed result carries data")

endmodule

// File: sv/message_header_deframer.sv
// Each byte is held in the input register; its result is held in the result register,
// which drives m_tvalid. Throughput: one byte per cycle; the two registers decouple the
// sides, so a stalled result holds input only when the held byte needs a result slot.
// Reset: clears both valid flags, sets the byte position to idle and loads the
// register defaults (magic 0, version 1, body length limit 65536).
// ----------------------------------------------------------------------------
// message_header_deframer
// Streams buffer bytes, gathers the 24-byte big-endian header, checks it and
// emits one result per buffer.
// ----------------------------------------------------------------------------
`include "message_header_deframer_defines.svh"

module message_header_deframer
	import mhd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // data_byte
	input  logic                  s_tuser,  // first_byte
	input  logic                  s_tlast,  // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[2:0], header_version[10:3], message_type[18:11], body_length[50:19],
	// sequence_number[114:51], timestamp[178:115], zero pad[183:179]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	mhd_cfg_t    cfg_q;
	logic        valid_s1;
	mhd_item_t   item_s1;
	logic        out_valid_q;
	mhd_result_t out_q;
	logic        hit;
	mhd_result_t res;
	logic        out_free;
	logic        consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic    <= 16'd0;
			cfg_q.supported_version <= 8'd1;
			cfg_q.body_length_limit <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAGIC:   cfg_q.expected_magic    <= cfg_data[15:0];
				CFG_VERSION: cfg_q.supported_version <= cfg_data[7:0];
				CFG_LIMIT:   cfg_q.body_length_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign consume  = valid_s1 && (!hit || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{data_byte: s_tdata, first_byte: s_tuser, last_byte: s_tlast};
		end
	end

	mhd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.item   (item_s1),
		.cfg    (cfg_q),
		.hit    (hit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && hit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && hit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.timestamp, out_q.sequence_number, out_q.body_length,
		out_q.message_type, out_q.header_version, out_q.status};

	`MHD_ASSERT(a_s1_hold, valid_s1 && !s_tready |=> valid_s1 && $stable(item_s1),
		"input stage lost a held byte")
	`MHD_ASSERT(a_no_overwrite, valid_s1 && hit && out_valid_q && !m_tready |-> !consume,
		"pending result overwritten")
	`MHD_ASSERT(a_status_code, out_valid_q |-> out_q.status == ST_OK ||
		out_q.status == ST_TOO_SHORT || out_q.status == ST_BAD_MAGIC ||
		out_q.status == ST_BAD_VERSION || out_q.status == ST_TOO_LONG,
		"result status out of range")

endmodule
